// ===== design/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DRDU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define DRDU_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`else
`define DRDU_ASSERT(name, clk, rst, prop)
`define DRDU_NEVER(name, clk, rst, expr)
`endif

`endif

// ===== design/drdu_pkg.sv =====
`default_nettype none
package drdu_pkg;

   localparam int ROW_FIELDS = 8;
   localparam int IDX_W      = 3;

   typedef logic [7:0] row_type;
   typedef row_type [ROW_FIELDS-1:0] frame_type;
   typedef logic [ROW_FIELDS-1:0] mask_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ONE,
      ST_LEAD,
      ST_DATA
   } state_type;

   typedef struct packed {
      logic     go;
      logic     bus_ok;
      mask_type dirty;
   } start_type;

   localparam row_type PAD_BYTE = 8'h00;

   function automatic logic [IDX_W-1:0] lowest_index(input mask_type m);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = ROW_FIELDS - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

// ===== design/drdu_lane.sv =====
`default_nettype none
module drdu_lane (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire drdu_pkg::row_type row,
   output logic                   dirty
);

   drdu_pkg::row_type shadow_ff;
   drdu_pkg::row_type shadow_in;

   assign shadow_in = load ? row : shadow_ff;
   assign dirty     = (row != shadow_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_ff <= '0;
      end else begin
         shadow_ff <= shadow_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/drdu_seq.sv =====
`default_nettype none
`include "assert_macros.svh"
module drdu_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire drdu_pkg::start_type start,
   input  wire drdu_pkg::frame_type frame,
   output logic                     idle,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_accepted,
   output logic                     rsp_byte_valid,
   output logic [7:0]               rsp_message_byte,
   output logic                     rsp_message_start,
   output logic                     rsp_message_end,
   output logic                     rsp_last
);

   drdu_pkg::state_type state_ff, state_in;
   drdu_pkg::mask_type  dirty_ff, dirty_in;
   drdu_pkg::mask_type  rem_ff, rem_in;
   drdu_pkg::frame_type frame_ff, frame_in;
   logic                bus_ok_ff, bus_ok_in;

   logic                valid_ff, valid_in;
   logic                accepted_ff, accepted_in;
   logic                byte_valid_ff, byte_valid_in;
   drdu_pkg::row_type   byte_ff, byte_in;
   logic                start_ff, start_in;
   logic                end_ff, end_in;
   logic                last_ff, last_in;

   logic                     out_free;
   logic                     load;
   drdu_pkg::mask_type       low;
   drdu_pkg::mask_type       rem_next;
   logic [drdu_pkg::IDX_W-1:0] cur;
   logic                     prev_dirty;
   logic                     next_dirty;

   assign out_free   = !valid_ff || rsp_ready;
   assign low        = rem_ff & (~rem_ff + 1'b1);
   assign rem_next   = rem_ff & ~low;
   assign cur        = drdu_pkg::lowest_index(rem_ff);
   assign prev_dirty = |(dirty_ff & (low >> 1));
   assign next_dirty = |(dirty_ff & (low << 1));
   assign idle       = (state_ff == drdu_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drdu_pkg::ST_IDLE: begin
            if (start.go) begin
               if (!start.bus_ok || start.dirty == '0) begin
                  state_in = drdu_pkg::ST_ONE;
               end else begin
                  state_in = drdu_pkg::ST_LEAD;
               end
            end
         end
         drdu_pkg::ST_ONE: begin
            if (out_free) begin
               state_in = drdu_pkg::ST_IDLE;
            end
         end
         drdu_pkg::ST_LEAD: begin
            if (out_free) begin
               state_in = drdu_pkg::ST_DATA;
            end
         end
         drdu_pkg::ST_DATA: begin
            if (out_free) begin
               state_in = (rem_next == '0) ? drdu_pkg::ST_IDLE : drdu_pkg::ST_LEAD;
            end
         end
         default: begin
            state_in = drdu_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      dirty_in      = dirty_ff;
      rem_in        = rem_ff;
      frame_in      = frame_ff;
      bus_ok_in     = bus_ok_ff;
      load          = 1'b0;
      accepted_in   = accepted_ff;
      byte_valid_in = byte_valid_ff;
      byte_in       = byte_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      last_in       = last_ff;
      case (state_ff)
         drdu_pkg::ST_IDLE: begin
            if (start.go) begin
               dirty_in  = start.dirty;
               rem_in    = start.dirty;
               frame_in  = frame;
               bus_ok_in = start.bus_ok;
            end
         end
         drdu_pkg::ST_ONE: begin
            load          = out_free;
            accepted_in   = bus_ok_ff;
            byte_valid_in = 1'b0;
            byte_in       = drdu_pkg::PAD_BYTE;
            start_in      = 1'b0;
            end_in        = 1'b0;
            last_in       = 1'b1;
         end
         drdu_pkg::ST_LEAD: begin
            load          = out_free;
            accepted_in   = 1'b1;
            byte_valid_in = 1'b1;
            byte_in       = prev_dirty ? drdu_pkg::PAD_BYTE : 8'({cur, 1'b0});
            start_in      = !prev_dirty;
            end_in        = 1'b0;
            last_in       = 1'b0;
         end
         drdu_pkg::ST_DATA: begin
            load          = out_free;
            accepted_in   = 1'b1;
            byte_valid_in = 1'b1;
            byte_in       = frame_ff[cur];
            start_in      = 1'b0;
            end_in        = !next_dirty;
            last_in       = (rem_next == '0);
            if (out_free) begin
               rem_in = rem_next;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drdu_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dirty_ff  <= dirty_in;
      rem_ff    <= rem_in;
      frame_ff  <= frame_in;
      bus_ok_ff <= bus_ok_in;
      if (load) begin
         accepted_ff   <= accepted_in;
         byte_valid_ff <= byte_valid_in;
         byte_ff       <= byte_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_accepted      = accepted_ff;
   assign rsp_byte_valid    = byte_valid_ff;
   assign rsp_message_byte  = byte_ff;
   assign rsp_message_start = start_ff;
   assign rsp_message_end   = end_ff;
   assign rsp_last          = last_ff;

   `DRDU_ASSERT(a_byte_needs_accept, clock, reset, (valid_ff && byte_valid_ff) |-> accepted_ff)
   `DRDU_ASSERT(a_start_is_open, clock, reset, (valid_ff && start_ff) |-> (byte_valid_ff && !end_ff && !last_ff))
   `DRDU_NEVER(a_lead_has_work, clock, reset, (state_ff == drdu_pkg::ST_LEAD || state_ff == drdu_pkg::ST_DATA) && rem_ff == '0)

endmodule
`default_nettype wire

// ===== design/dirty_row_display_update.sv =====
// accept first moves the sequencer state; the output register then loads the first result once free
// each request gives n results, n = 2 x changed rows (1 if none or bus busy), 1..16
// the sequencer emits one result per cycle unless stalled, taking requests only when idle
// reset: synchronous active high, clears the shadow rows to zero and empties the output
`default_nettype none
`include "assert_macros.svh"
module dirty_row_display_update #(
   parameter int ROWS = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_bus_ready,
   input  wire logic [7:0] req_row_0,
   input  wire logic [7:0] req_row_1,
   input  wire logic [7:0] req_row_2,
   input  wire logic [7:0] req_row_3,
   input  wire logic [7:0] req_row_4,
   input  wire logic [7:0] req_row_5,
   input  wire logic [7:0] req_row_6,
   input  wire logic [7:0] req_row_7,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_accepted,
   output logic            rsp_byte_valid,
   output logic [7:0]      rsp_message_byte,
   output logic            rsp_message_start,
   output logic            rsp_message_end,
   output logic            rsp_last
);

   localparam int ACTIVE_ROWS = (ROWS < drdu_pkg::ROW_FIELDS) ? ROWS : drdu_pkg::ROW_FIELDS;

   drdu_pkg::frame_type frame;
   drdu_pkg::mask_type  dirty;
   drdu_pkg::start_type start;
   logic                accept;
   logic                idle;

   assign frame[0] = req_row_0;
   assign frame[1] = req_row_1;
   assign frame[2] = req_row_2;
   assign frame[3] = req_row_3;
   assign frame[4] = req_row_4;
   assign frame[5] = req_row_5;
   assign frame[6] = req_row_6;
   assign frame[7] = req_row_7;

   assign req_ready = idle;
   assign accept    = req_valid && idle;

   // one compare lane per active row, each holding its shadow row
   for (genvar i = 0; i < drdu_pkg::ROW_FIELDS; i++) begin : g_lane
      if (i < ACTIVE_ROWS) begin : g_on
         drdu_lane u_lane (
            .clock (clock),
            .reset (reset),
            .load  (accept && req_bus_ready),
            .row   (frame[i]),
            .dirty (dirty[i])
         );
      end else begin : g_off
         assign dirty[i] = 1'b0;
      end
   end

   assign start.go     = accept;
   assign start.bus_ok = req_bus_ready;
   assign start.dirty  = dirty;

   drdu_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .frame             (frame),
      .idle              (idle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_message_byte  (rsp_message_byte),
      .rsp_message_start (rsp_message_start),
      .rsp_message_end   (rsp_message_end),
      .rsp_last          (rsp_last)
   );

   `DRDU_ASSERT(a_one_request_at_a_time, clock, reset, accept |=> !req_ready)
   `DRDU_ASSERT(a_request_gives_result, clock, reset, accept |=> ##1 rsp_valid)
   `DRDU_NEVER(a_idle_without_last, clock, reset, $rose(req_ready) && !(rsp_valid && rsp_last))

endmodule
`default_nettype wire
